// ----- src/assert_macros.svh -----
// assertion macros, included by the controller
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(name, clk, rst_n, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ----- src/egpe_pkg.sv -----
// constants, command and status types for the genotype prior estimator
package egpe_pkg;

    localparam int MAX_GENOTYPES   = 16;
    localparam int MAX_INDIVIDUALS = 1024;

    localparam int GEN_W    = $clog2(MAX_GENOTYPES);
    localparam int GCNT_W   = $clog2(MAX_GENOTYPES + 1);
    localparam int ROW_W    = $clog2(MAX_INDIVIDUALS + 1);
    localparam int RIDX_W   = $clog2(MAX_INDIVIDUALS);
    localparam int ADDR_W   = RIDX_W + GEN_W;
    localparam int DEPTH    = MAX_GENOTYPES * MAX_INDIVIDUALS;

    localparam int LIK_W      = 32;
    localparam int CFG_G_W    = 5;
    localparam int LIMIT_W    = 10;
    localparam int TOL_W      = 32;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int STATUS_W   = 2;

    localparam int SUM_W   = LIK_W + GEN_W;
    localparam int WSUM_W  = 48;
    localparam int TOT_W   = WSUM_W + GEN_W;
    localparam int QUOT_W  = LIK_W + 1;
    localparam int LL_W    = 64;
    localparam int EXP_W   = $clog2(SUM_W);

    localparam logic [ROW_W-1:0] ROW_MAX = ROW_W'(MAX_INDIVIDUALS);
    localparam logic [31:0]      LN2_Q32 = 32'd2977044472;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GENOTYPES   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROUND_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE   = 2'd2;

    localparam logic [CFG_G_W-1:0] G_RESET     = 5'd3;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 10'd100;
    localparam logic [TOL_W-1:0]   TOL_RESET   = 32'd42950;

    // run status codes
    localparam logic [STATUS_W-1:0] ST_CONVERGED   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ROUND_LIMIT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DECREASED   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW    = 2'd3;

    // uniform start prior floor(2^32 / g), all ones for a single genotype
    function automatic logic [31:0] uniform_prior(input logic [GCNT_W-1:0] g);
        logic [31:0] u;
        case (g)
            5'd2:    u = 32'd2147483648;
            5'd3:    u = 32'd1431655765;
            5'd4:    u = 32'd1073741824;
            5'd5:    u = 32'd858993459;
            5'd6:    u = 32'd715827882;
            5'd7:    u = 32'd613566756;
            5'd8:    u = 32'd536870912;
            5'd9:    u = 32'd477218588;
            5'd10:   u = 32'd429496729;
            5'd11:   u = 32'd390451572;
            5'd12:   u = 32'd357913941;
            5'd13:   u = 32'd330382099;
            5'd14:   u = 32'd306783378;
            5'd15:   u = 32'd286331153;
            5'd16:   u = 32'd268435456;
            default: u = 32'hFFFF_FFFF;
        endcase
        return u;
    endfunction

    typedef struct packed {
        logic                load;
        logic                clr_counters;
        logic                init_run;
        logic                ovf_run;
        logic                pass_start;
        logic                row_start;
        logic                rd;
        logic                mul;
        logic                acc;
        logic                k_clr;
        logic                k_inc;
        logic                div_post_start;
        logic                ln_start;
        logic                post_add;
        logic                ln_add;
        logic                row_next;
        logic                keep_ll;
        logic                tot_add;
        logic                div_prior_start;
        logic                prior_set;
        logic                round_inc;
        logic                status_we;
        logic [STATUS_W-1:0] status;
        logic                emit;
    } t_cmd;

    typedef struct packed {
        logic overflow;
        logic limit_zero;
        logic rows_done;
        logic k_last;
        logic s_zero;
        logic div_busy;
        logic ln_busy;
        logic round_zero;
        logic ll_dec;
        logic ll_conv;
        logic round_at_limit;
        logic total_zero;
        logic out_free;
    } t_sts;

endpackage

// ----- src/egpe_div.sv -----
// restoring divider, floor(num * 2^32 / den) for num <= den, one bit per cycle
module egpe_div import egpe_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [TOT_W-1:0]  i_num,
    input  logic [TOT_W-1:0]  i_den,
    output logic              o_busy,
    output logic [QUOT_W-1:0] o_quot
);

    localparam int STEP_W = $clog2(QUOT_W);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(QUOT_W - 1);

    logic              r_busy;
    logic [STEP_W-1:0] r_step;
    logic [TOT_W:0]    r_rem;
    logic [TOT_W-1:0]  r_den;
    logic [QUOT_W-1:0] r_quot;
    logic [TOT_W:0]    trial;
    logic              ge;

    // first step compares without a shift
    assign trial = (r_step == '0) ? r_rem : {r_rem[TOT_W-1:0], 1'b0};
    assign ge    = (trial >= {1'b0, r_den});

    // step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= '0;
        end else if (r_busy) begin
            r_step <= r_step + STEP_W'(1);
            if (r_step == STEP_LAST) begin
                r_busy <= 1'b0;
            end
        end
    end

    // remainder and quotient
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= {1'b0, i_num};
            r_den  <= i_den;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= ge ? (trial - {1'b0, r_den}) : trial;
            r_quot <= {r_quot[QUOT_W-2:0], ge};
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;

endmodule

// ----- src/egpe_ln.sv -----
// natural log of a row sum in q31.32, normalize then square bit by bit
module egpe_ln import egpe_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [SUM_W-1:0] i_sum,
    output logic             o_busy,
    output logic [LL_W-1:0]  o_ln
);

    typedef enum logic [5:0] {
        LN_IDLE = 6'b000001,
        LN_NORM = 6'b000010,
        LN_SQR  = 6'b000100,
        LN_MAG  = 6'b001000,
        LN_MUL  = 6'b010000,
        LN_FIN  = 6'b100000
    } t_ln_phase;

    localparam logic [EXP_W-1:0] EXP_ONE = EXP_W'(LIK_W);

    t_ln_phase          r_phase;
    logic [SUM_W-1:0]   r_norm;
    logic [EXP_W-1:0]   r_exp;
    logic [31:0]        r_y;
    logic [31:0]        r_frac;
    logic [4:0]         r_cnt;
    logic               r_neg;
    logic [EXP_W-1:0]   r_mag_hi;
    logic [31:0]        r_mag_lo;
    logic [EXP_W+31:0]  r_p_hi;
    logic [63:0]        r_p_lo;
    logic [LL_W-1:0]    r_ln;
    logic [63:0]        sq;
    logic [32:0]        sq_t;
    logic [EXP_W+32:0]  lnmag;

    assign sq    = r_y * r_y;
    assign sq_t  = sq[63:31];
    assign lnmag = (EXP_W+33)'(r_p_hi) + (EXP_W+33)'(r_p_lo[63:32]);

    // phase sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= LN_IDLE;
            r_cnt   <= '0;
        end else begin
            case (r_phase)
                LN_IDLE: begin
                    if (i_start) begin
                        r_phase <= LN_NORM;
                    end
                end
                LN_NORM: begin
                    if (r_norm[SUM_W-1]) begin
                        r_phase <= LN_SQR;
                        r_cnt   <= '0;
                    end
                end
                LN_SQR: begin
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd31) begin
                        r_phase <= LN_MAG;
                    end
                end
                LN_MAG:  r_phase <= LN_MUL;
                LN_MUL:  r_phase <= LN_FIN;
                LN_FIN:  r_phase <= LN_IDLE;
                default: r_phase <= LN_IDLE;
            endcase
        end
    end

    // datapath of the log unit
    always_ff @(posedge i_clk) begin
        case (r_phase)
            LN_IDLE: begin
                if (i_start) begin
                    r_norm <= i_sum;
                    r_exp  <= EXP_W'(SUM_W - 1);
                end
            end
            LN_NORM: begin
                // shift until the leading one is at the top
                if (r_norm[SUM_W-1]) begin
                    r_y    <= r_norm[SUM_W-1 -: 32];
                    r_frac <= '0;
                end else begin
                    r_norm <= {r_norm[SUM_W-2:0], 1'b0};
                    r_exp  <= r_exp - EXP_W'(1);
                end
            end
            LN_SQR: begin
                // one fraction bit of log2 per squaring
                r_y    <= sq_t[32] ? sq_t[32:1] : sq_t[31:0];
                r_frac <= {r_frac[30:0], sq_t[32]};
            end
            LN_MAG: begin
                if (r_exp >= EXP_ONE) begin
                    r_neg    <= 1'b0;
                    r_mag_hi <= r_exp - EXP_ONE;
                    r_mag_lo <= r_frac;
                end else begin
                    r_neg    <= 1'b1;
                    r_mag_hi <= (EXP_ONE - r_exp) - EXP_W'(r_frac != '0);
                    r_mag_lo <= 32'd0 - r_frac;
                end
            end
            LN_MUL: begin
                r_p_hi <= r_mag_hi * LN2_Q32;
                r_p_lo <= r_mag_lo * LN2_Q32;
            end
            LN_FIN: begin
                r_ln <= r_neg ? (LL_W'(0) - LL_W'(lnmag)) : LL_W'(lnmag);
            end
            default: begin
            end
        endcase
    end

    assign o_busy = (r_phase != LN_IDLE);
    assign o_ln   = r_ln;

endmodule

// ----- src/egpe_dp.sv -----
// datapath: config, likelihood memory, priors, weight sums, log-likelihood, output word
module egpe_dp import egpe_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [LIK_W-1:0]      i_likelihood,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [31:0]           o_prior,
    output logic [GEN_W-1:0]      o_genotype,
    output logic [STATUS_W-1:0]   o_status,
    output logic [LIMIT_W-1:0]    o_rounds_used,
    output logic                  o_last_result
);

    logic [CFG_G_W-1:0]  r_cfg_g;
    logic [LIMIT_W-1:0]  r_cfg_limit;
    logic [TOL_W-1:0]    r_cfg_tol;
    logic [GCNT_W-1:0]   g_eff;

    logic [ROW_W-1:0]    r_row;
    logic [GEN_W-1:0]    r_col;
    logic                r_ovf;
    logic [LIK_W-1:0]    r_lik_mem [DEPTH];
    logic [LIK_W-1:0]    r_rdata;

    logic [GEN_W-1:0]    r_k;
    logic [ROW_W-1:0]    r_row_ptr;
    logic [31:0]         r_prior [MAX_GENOTYPES];
    logic [31:0]         r_prod  [MAX_GENOTYPES];
    logic [WSUM_W-1:0]   r_wsum  [MAX_GENOTYPES];
    logic [31:0]         r_prod_tmp;
    logic [SUM_W-1:0]    r_sum;
    logic [TOT_W-1:0]    r_total;
    logic [LL_W-1:0]     r_ll;
    logic [LL_W-1:0]     r_prev;
    logic [LIMIT_W-1:0]  r_round;
    logic [STATUS_W-1:0] r_status;

    logic                r_out_valid;
    logic [31:0]         r_out_prior;
    logic [GEN_W-1:0]    r_out_gen;
    logic [STATUS_W-1:0] r_out_status;
    logic [LIMIT_W-1:0]  r_out_rounds;
    logic                r_out_last;

    logic [63:0]         prod_full;
    logic [WSUM_W:0]     w_add;
    logic [LL_W-1:0]     ll_diff;
    logic [TOT_W-1:0]    div_num;
    logic [TOT_W-1:0]    div_den;
    logic [QUOT_W-1:0]   div_q;
    logic                div_busy;
    logic [31:0]         prior_q;
    logic [LL_W-1:0]     ln_val;
    logic                ln_busy;
    logic                k_last;
    logic                out_free;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_g     <= G_RESET;
            r_cfg_limit <= LIMIT_RESET;
            r_cfg_tol   <= TOL_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_GENOTYPES:   r_cfg_g     <= i_cfg_data[CFG_G_W-1:0];
                REG_ROUND_LIMIT: r_cfg_limit <= i_cfg_data[LIMIT_W-1:0];
                REG_TOLERANCE:   r_cfg_tol   <= i_cfg_data[TOL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // genotype count clamped to 1..max
    always_comb begin
        if (r_cfg_g == '0) begin
            g_eff = GCNT_W'(1);
        end else if (r_cfg_g > CFG_G_W'(MAX_GENOTYPES)) begin
            g_eff = GCNT_W'(MAX_GENOTYPES);
        end else begin
            g_eff = GCNT_W'(r_cfg_g);
        end
    end

    // load counters, extra rows only raise the overflow flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clr_counters) begin
            r_row <= '0;
            r_col <= '0;
            r_ovf <= 1'b0;
        end else if (i_cmd.load) begin
            if (r_row >= ROW_MAX) begin
                r_ovf <= 1'b1;
            end else if (GCNT_W'(r_col) + GCNT_W'(1) >= g_eff) begin
                r_col <= '0;
                r_row <= r_row + ROW_W'(1);
            end else begin
                r_col <= r_col + GEN_W'(1);
            end
        end
    end

    // likelihood memory, fixed row stride
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && (r_row < ROW_MAX)) begin
            r_lik_mem[{r_row[RIDX_W-1:0], r_col}] <= i_likelihood;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rdata <= r_lik_mem[{r_row_ptr[RIDX_W-1:0], r_k}];
        end
    end

    // genotype index, row pointer, round counter, status
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k       <= '0;
            r_row_ptr <= '0;
            r_round   <= '0;
            r_status  <= ST_CONVERGED;
        end else begin
            if (i_cmd.k_clr) begin
                r_k <= '0;
            end else if (i_cmd.k_inc) begin
                r_k <= r_k + GEN_W'(1);
            end
            if (i_cmd.pass_start) begin
                r_row_ptr <= '0;
            end else if (i_cmd.row_next) begin
                r_row_ptr <= r_row_ptr + ROW_W'(1);
            end
            if (i_cmd.init_run || i_cmd.ovf_run) begin
                r_round <= '0;
            end else if (i_cmd.round_inc) begin
                r_round <= r_round + LIMIT_W'(1);
            end
            if (i_cmd.status_we) begin
                r_status <= i_cmd.status;
            end
        end
    end

    assign k_last    = (GCNT_W'(r_k) == (g_eff - GCNT_W'(1)));
    assign prod_full = r_rdata * r_prior[r_k];
    assign w_add     = (WSUM_W+1)'(r_wsum[r_k]) + (WSUM_W+1)'(div_q);
    assign prior_q   = div_q[QUOT_W-1] ? 32'hFFFF_FFFF : div_q[31:0];

    // priors: uniform start, zero on overflow, quotient per genotype
    always_ff @(posedge i_clk) begin
        if (i_cmd.init_run) begin
            for (int j = 0; j < MAX_GENOTYPES; j++) begin
                r_prior[j] <= (GCNT_W'(j) < g_eff) ? uniform_prior(g_eff) : 32'd0;
            end
        end else if (i_cmd.ovf_run) begin
            for (int j = 0; j < MAX_GENOTYPES; j++) begin
                r_prior[j] <= 32'd0;
            end
        end else if (i_cmd.prior_set) begin
            r_prior[r_k] <= prior_q;
        end
    end

    // row products
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod_tmp <= prod_full[63:32];
        end
        if (i_cmd.acc) begin
            r_prod[r_k] <= r_prod_tmp;
        end
    end

    // saturating posterior sums per genotype
    always_ff @(posedge i_clk) begin
        if (i_cmd.pass_start) begin
            for (int j = 0; j < MAX_GENOTYPES; j++) begin
                r_wsum[j] <= '0;
            end
        end else if (i_cmd.post_add) begin
            r_wsum[r_k] <= w_add[WSUM_W] ? {WSUM_W{1'b1}} : w_add[WSUM_W-1:0];
        end
    end

    // row sum, weight total, log-likelihood
    always_ff @(posedge i_clk) begin
        if (i_cmd.row_start) begin
            r_sum <= '0;
        end else if (i_cmd.acc) begin
            r_sum <= r_sum + SUM_W'(r_prod_tmp);
        end
        if (i_cmd.pass_start) begin
            r_total <= '0;
            r_ll    <= '0;
        end else begin
            if (i_cmd.tot_add) begin
                r_total <= r_total + TOT_W'(r_wsum[r_k]);
            end
            if (i_cmd.ln_add) begin
                r_ll <= r_ll + ln_val;
            end
        end
        if (i_cmd.keep_ll) begin
            r_prev <= r_ll;
        end
    end

    // shared divider: posterior or new prior
    assign div_num = i_cmd.div_post_start ? TOT_W'(r_prod[r_k]) : TOT_W'(r_wsum[r_k]);
    assign div_den = i_cmd.div_post_start ? TOT_W'(r_sum) : r_total;

    egpe_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_post_start || i_cmd.div_prior_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_quot  (div_q)
    );

    egpe_ln u_ln (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.ln_start),
        .i_sum   (r_sum),
        .o_busy  (ln_busy),
        .o_ln    (ln_val)
    );

    // output word register
    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_prior  <= r_prior[r_k];
            r_out_gen    <= r_k;
            r_out_status <= r_status;
            r_out_rounds <= r_round;
            r_out_last   <= k_last;
        end
    end

    // status toward the controller
    assign ll_diff = r_ll - r_prev;

    always_comb begin
        o_sts.overflow       = r_ovf;
        o_sts.limit_zero     = (r_cfg_limit == '0);
        o_sts.rows_done      = (r_row_ptr == r_row);
        o_sts.k_last         = k_last;
        o_sts.s_zero         = (r_sum == '0);
        o_sts.div_busy       = div_busy;
        o_sts.ln_busy        = ln_busy;
        o_sts.round_zero     = (r_round == '0);
        o_sts.ll_dec         = ($signed(r_ll) < $signed(r_prev));
        o_sts.ll_conv        = (ll_diff <= LL_W'(r_cfg_tol));
        o_sts.round_at_limit = (r_round == r_cfg_limit);
        o_sts.total_zero     = (r_total == '0);
        o_sts.out_free       = out_free;
    end

    assign o_out_valid   = r_out_valid;
    assign o_prior       = r_out_prior;
    assign o_genotype    = r_out_gen;
    assign o_status      = r_out_status;
    assign o_rounds_used = r_out_rounds;
    assign o_last_result = r_out_last;

endmodule

// ----- src/egpe_ctrl.sv -----
// controller: load, em passes, prior update and result sequencing
`include "assert_macros.svh"

module egpe_ctrl import egpe_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_last_item,
    output logic o_in_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [16:0] {
        S_IDLE      = 17'b00000000000000001,
        S_START     = 17'b00000000000000010,
        S_PASS      = 17'b00000000000000100,
        S_ROW       = 17'b00000000000001000,
        S_RD        = 17'b00000000000010000,
        S_MUL       = 17'b00000000000100000,
        S_ACC       = 17'b00000000001000000,
        S_ROW_CHK   = 17'b00000000010000000,
        S_DIV_GO    = 17'b00000000100000000,
        S_DIV_WAIT  = 17'b00000001000000000,
        S_LN_WAIT   = 17'b00000010000000000,
        S_EVAL      = 17'b00000100000000000,
        S_TOT       = 17'b00001000000000000,
        S_NCHK      = 17'b00010000000000000,
        S_NORM_GO   = 17'b00100000000000000,
        S_NORM_WAIT = 17'b01000000000000000,
        S_OUT       = 17'b10000000000000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.load = i_in_valid;
                if (i_in_valid && i_last_item) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                o_cmd.k_clr = 1'b1;
                if (i_sts.overflow) begin
                    o_cmd.ovf_run   = 1'b1;
                    o_cmd.status_we = 1'b1;
                    o_cmd.status    = ST_OVERFLOW;
                    n_state         = S_OUT;
                end else begin
                    o_cmd.init_run = 1'b1;
                    if (i_sts.limit_zero) begin
                        o_cmd.status_we = 1'b1;
                        o_cmd.status    = ST_ROUND_LIMIT;
                        n_state         = S_OUT;
                    end else begin
                        n_state = S_PASS;
                    end
                end
            end
            S_PASS: begin
                o_cmd.pass_start = 1'b1;
                n_state          = S_ROW;
            end
            S_ROW: begin
                if (i_sts.rows_done) begin
                    n_state = S_EVAL;
                end else begin
                    o_cmd.row_start = 1'b1;
                    o_cmd.k_clr     = 1'b1;
                    n_state         = S_RD;
                end
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                if (i_sts.k_last) begin
                    o_cmd.k_clr = 1'b1;
                    n_state     = S_ROW_CHK;
                end else begin
                    o_cmd.k_inc = 1'b1;
                    n_state     = S_RD;
                end
            end
            S_ROW_CHK: begin
                // rows that sum to zero take no part
                if (i_sts.s_zero) begin
                    o_cmd.row_next = 1'b1;
                    n_state        = S_ROW;
                end else begin
                    o_cmd.ln_start       = 1'b1;
                    o_cmd.div_post_start = 1'b1;
                    n_state              = S_DIV_WAIT;
                end
            end
            S_DIV_GO: begin
                o_cmd.div_post_start = 1'b1;
                n_state              = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (!i_sts.div_busy) begin
                    o_cmd.post_add = 1'b1;
                    if (i_sts.k_last) begin
                        o_cmd.k_clr = 1'b1;
                        n_state     = S_LN_WAIT;
                    end else begin
                        o_cmd.k_inc = 1'b1;
                        n_state     = S_DIV_GO;
                    end
                end
            end
            S_LN_WAIT: begin
                if (!i_sts.ln_busy) begin
                    o_cmd.ln_add   = 1'b1;
                    o_cmd.row_next = 1'b1;
                    n_state        = S_ROW;
                end
            end
            S_EVAL: begin
                // stop checks in the order decrease, tolerance, limit
                if (i_sts.round_zero) begin
                    o_cmd.keep_ll = 1'b1;
                    o_cmd.k_clr   = 1'b1;
                    n_state       = S_TOT;
                end else if (i_sts.ll_dec) begin
                    o_cmd.status_we = 1'b1;
                    o_cmd.status    = ST_DECREASED;
                    o_cmd.k_clr     = 1'b1;
                    n_state         = S_OUT;
                end else if (i_sts.ll_conv) begin
                    o_cmd.status_we = 1'b1;
                    o_cmd.status    = ST_CONVERGED;
                    o_cmd.k_clr     = 1'b1;
                    n_state         = S_OUT;
                end else if (i_sts.round_at_limit) begin
                    o_cmd.status_we = 1'b1;
                    o_cmd.status    = ST_ROUND_LIMIT;
                    o_cmd.k_clr     = 1'b1;
                    n_state         = S_OUT;
                end else begin
                    o_cmd.keep_ll = 1'b1;
                    o_cmd.k_clr   = 1'b1;
                    n_state       = S_TOT;
                end
            end
            S_TOT: begin
                o_cmd.tot_add = 1'b1;
                if (i_sts.k_last) begin
                    o_cmd.k_clr = 1'b1;
                    n_state     = S_NCHK;
                end else begin
                    o_cmd.k_inc = 1'b1;
                end
            end
            S_NCHK: begin
                // all weights zero keeps the priors
                if (i_sts.total_zero) begin
                    o_cmd.round_inc = 1'b1;
                    n_state         = S_PASS;
                end else begin
                    o_cmd.div_prior_start = 1'b1;
                    n_state               = S_NORM_WAIT;
                end
            end
            S_NORM_GO: begin
                o_cmd.div_prior_start = 1'b1;
                n_state               = S_NORM_WAIT;
            end
            S_NORM_WAIT: begin
                if (!i_sts.div_busy) begin
                    o_cmd.prior_set = 1'b1;
                    if (i_sts.k_last) begin
                        o_cmd.k_clr     = 1'b1;
                        o_cmd.round_inc = 1'b1;
                        n_state         = S_PASS;
                    end else begin
                        o_cmd.k_inc = 1'b1;
                        n_state     = S_NORM_GO;
                    end
                end
            end
            S_OUT: begin
                o_cmd.clr_counters = 1'b1;
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.k_last) begin
                        o_cmd.k_clr = 1'b1;
                        n_state     = S_IDLE;
                    end else begin
                        o_cmd.k_inc = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // checks
    `ASSERT_CLK(a_last_starts_run, i_clk, i_rst_n, (i_in_valid && !o_in_stall && i_last_item) |=> (r_state == S_START), "last word did not start a run")
    `ASSERT_NEVER(a_idle_div_busy, i_clk, i_rst_n, (r_state == S_IDLE) && i_sts.div_busy, "divider busy while idle")
    `ASSERT_NEVER(a_post_div_zero, i_clk, i_rst_n, o_cmd.div_post_start && i_sts.s_zero, "posterior divide by zero row sum")

endmodule

// ----- src/em_genotype_prior_estimator.sv -----
// top level of the em genotype prior estimator
// Usage: likelihood words enter on the input channel (i_in_valid / o_in_stall),
// one matrix entry per word in row-major order, genotypes_in_use entries a row.
// While loading, a word is taken every cycle. The word with i_last_item set is
// stored and starts an em run; o_in_stall stays high until the last result of
// the run has been placed in the output register.
// A run makes one pass over the stored rows per round. A row with nonzero sum
// is read and multiplied per genotype, then takes G divisions with the log unit
// running beside them; a zero row takes only the reads and multiplies. Each
// round adds weight sums and, unless all weights are zero, G prior divisions.
// The run ends after at most round_limit rounds. Then G result words go out on
// o_out_valid / i_out_stall, one per cycle while the receiver does not stall; a
// stalled word holds in the output register. Configuration is written through
// i_cfg_we / i_cfg_index / i_cfg_data; the user must write it only while the
// block is idle, which the block itself does not enforce. Reset (synchronous,
// active low) returns the registers to their defaults and clears the row,
// column and overflow counts; the likelihood memory is not cleared.
module em_genotype_prior_estimator import egpe_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [LIK_W-1:0]      i_likelihood,
    input  logic                  i_last_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [31:0]           o_prior,
    output logic [GEN_W-1:0]      o_genotype,
    output logic [STATUS_W-1:0]   o_status,
    output logic [LIMIT_W-1:0]    o_rounds_used,
    output logic                  o_last_result
);

    t_cmd cmd;
    t_sts sts;

    egpe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_last_item (i_last_item),
        .o_in_stall  (o_in_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    egpe_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_likelihood  (i_likelihood),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_prior       (o_prior),
        .o_genotype    (o_genotype),
        .o_status      (o_status),
        .o_rounds_used (o_rounds_used),
        .o_last_result (o_last_result)
    );

endmodule
